[rtl/core/gsmr_pkg.sv]
// Shared types, constants and button assembly for the gamepad select multiplex reader.
package gsmr_pkg;

    localparam int PORT_COUNT = 2;

    localparam int PINS_W    = 6;
    localparam int BUTTONS_W = 12;

    // Phase of a port within one poll; even phases sample with select low.
    localparam logic [2:0] PH_PAIR1_LOW  = 3'd0;
    localparam logic [2:0] PH_PAIR1_HIGH = 3'd1;
    localparam logic [2:0] PH_PAIR3_HIGH = 3'd5;
    localparam logic [2:0] PH_PAIR4_LOW  = 3'd6;
    localparam logic [2:0] PH_PAIR4_HIGH = 3'd7;

    localparam logic [3:0]           NIBBLE_ONES  = 4'hF;
    localparam logic [BUTTONS_W-1:0] BUTTONS_MASK = 12'h0FFF;

    typedef struct packed {
        logic                 port;
        logic [PINS_W-1:0]    pins;
    } t_in_item;

    typedef struct packed {
        logic [2:0]           phase;
        logic                 six_mode;
        logic [1:0]           first_low;
        logic [5:0]           first_high;
        logic [3:0]           extra_nibble;
        logic [BUTTONS_W-1:0] held_buttons;
    } t_port_state;

    typedef struct packed {
        logic                 select_level;
        logic                 poll_done;
        logic [BUTTONS_W-1:0] buttons;
        logic                 pad_six;
    } t_result;

    localparam t_port_state PORT_STATE_RESET = '{
        phase:        PH_PAIR1_LOW,
        six_mode:     1'b1,
        first_low:    2'b00,
        first_high:   6'b000000,
        extra_nibble: 4'h0,
        held_buttons: '0
    };

    // Raw pins are active low; three-button pads report the top nibble released.
    function automatic logic [BUTTONS_W-1:0] assemble(
        input logic [1:0] low,
        input logic [5:0] high,
        input logic [3:0] extra,
        input logic       six
    );
        logic [BUTTONS_W-1:0] raw;
        raw = {(six ? extra : NIBBLE_ONES), low, high};
        return (raw ^ BUTTONS_MASK) & BUTTONS_MASK;
    endfunction

endpackage

[rtl/core/gsmr_in_reg.sv]
// Input register stage: captures one sample item and holds it while the result side is busy.
module gsmr_in_reg
    import gsmr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_port,
    input  logic [PINS_W-1:0] i_pins,
    input  logic              i_advance,
    output logic              o_stall,
    output logic              o_item_valid,
    output t_in_item          o_item
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     load;

    assign o_stall = r_valid && !i_advance;
    assign load    = i_valid && !o_stall;

    always_comb begin
        if (load) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.port <= i_port;
            r_item.pins <= i_pins;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

[rtl/core/gsmr_step.sv]
// Per-sample phase update and button assembly for one port.
module gsmr_step
    import gsmr_pkg::*;
(
    input  t_port_state       i_state,
    input  logic [PINS_W-1:0] i_pins,
    output t_port_state       o_state,
    output t_result           o_result
);

    logic done;

    always_comb begin
        o_state = i_state;
        done    = 1'b0;
        unique case (i_state.phase)
            PH_PAIR1_LOW: begin
                o_state.first_low = i_pins[5:4];
            end
            PH_PAIR1_HIGH: begin
                o_state.first_high = i_pins;
                if (!i_state.six_mode) begin
                    o_state.held_buttons = assemble(i_state.first_low, i_pins,
                                                    i_state.extra_nibble, 1'b0);
                    done = 1'b1;
                end
            end
            PH_PAIR3_HIGH: begin
                o_state.extra_nibble = i_pins[3:0];
            end
            PH_PAIR4_LOW: begin
                if (i_pins[3:0] != NIBBLE_ONES) begin
                    o_state.six_mode = 1'b0;
                end
            end
            PH_PAIR4_HIGH: begin
                o_state.held_buttons = assemble(i_state.first_low, i_state.first_high,
                                                i_state.extra_nibble, i_state.six_mode);
                done = 1'b1;
            end
            default: begin
            end
        endcase
        o_state.phase = done ? PH_PAIR1_LOW : i_state.phase + 3'd1;

        o_result.select_level = o_state.phase[0];
        o_result.poll_done    = done;
        o_result.buttons      = o_state.held_buttons;
        o_result.pad_six      = o_state.six_mode;
    end

endmodule

[rtl/core/gamepad_select_multiplex_reader_unit.sv]
// The result is registered: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle unless stalled, any mix of ports; port state updates per item.
// A pending result holds in the output register while the next item waits in the input register.
// Reset (synchronous, active low) clears valids; every port returns to phase zero, six-button
// mode assumed, with captured bits and held buttons zero.
module gamepad_select_multiplex_reader_unit
    import gsmr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_port,
    input  logic [PINS_W-1:0]    i_pins,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_select_level,
    output logic                 o_poll_done,
    output logic [BUTTONS_W-1:0] o_buttons,
    output logic                 o_pad_six
);

    logic        advance;
    logic        item_valid;
    t_in_item    item;
    logic        port_ok;
    t_port_state cur_state;
    t_port_state step_state;
    t_result     step_result;
    t_result     n_result;

    t_port_state r_state [PORT_COUNT];
    logic        r_out_valid;
    t_result     r_result;

    assign advance = !r_out_valid || !i_stall;

    gsmr_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_port       (i_port),
        .i_pins       (i_pins),
        .i_advance    (advance),
        .o_stall      (o_stall),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    assign port_ok   = (32'(item.port) < PORT_COUNT);
    assign cur_state = port_ok ? r_state[item.port] : PORT_STATE_RESET;

    gsmr_step u_step (
        .i_state  (cur_state),
        .i_pins   (item.pins),
        .o_state  (step_state),
        .o_result (step_result)
    );

    // Samples on an absent port leave state alone and report all zeros.
    assign n_result = port_ok ? step_result : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PORT_COUNT; p++) begin
                r_state[p] <= PORT_STATE_RESET;
            end
        end else if (item_valid && advance && port_ok) begin
            r_state[item.port] <= step_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && item_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_select_level = r_result.select_level;
    assign o_poll_done    = r_result.poll_done;
    assign o_buttons      = r_result.buttons;
    assign o_pad_six      = r_result.pad_six;

endmodule
